>>> sv/gnta_pkg.sv
// ----------------------------------------------------------------------------
// gnta_pkg: shared types and constants for gated nearest track association
// Payload structs, request codes, state enums and size constants.
// ----------------------------------------------------------------------------
package gnta_pkg;

    localparam int TRUTH_DEPTH_DEF   = 64;
    localparam int HISTORY_DEPTH_DEF = 1024;
    localparam int CFG_IDX_W         = 2;
    localparam int CFG_DATA_W        = 16;
    localparam int SUM_W             = 38;
    localparam int TALLY_W           = 16;
    localparam int AVG_W             = 22;
    localparam int COORD_W           = 20;
    localparam int SQ_W              = 43;
    localparam int DIST_W            = 22;

    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_TRACK = 2'd1;
    localparam logic [1:0] REQ_EOF   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_GATE_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GATE_SLOPE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DEPTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEF_DEPTH  = 2'd3;

    typedef struct packed {
        logic [1:0]          req_type;
        logic signed [19:0]  pos_x;
        logic signed [19:0]  pos_y;
        logic signed [19:0]  pos_z;
        logic [15:0]         object_id;
        logic                track_active;
    } gnta_in_t;

    typedef struct packed {
        logic [15:0] active_tracks;
        logic [15:0] ident_changes;
        logic [15:0] fragmentations;
        logic [15:0] matched_pairs;
        logic [21:0] avg_error_mm;
        logic        truth_dropped;
    } gnta_out_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_RD, ST_SQ, ST_SUM, ST_ROOT, ST_NEXT, ST_GATE, ST_HRD, ST_HWAIT,
        ST_HUPD, ST_DIV, ST_OUT
    } gnta_state_t;

    function automatic logic [TALLY_W-1:0] sat_inc(input logic [TALLY_W-1:0] v);
        logic [TALLY_W-1:0] r;
        r = (v == {TALLY_W{1'b1}}) ? v : v + 1'b1;
        return r;
    endfunction

endpackage

>>> sv/gated_nearest_track_association_unit.sv
// ----------------------------------------------------------------------------
// gated_nearest_track_association_unit: top level
// Per-frame nearest-neighbor gated association with identity history.
// ----------------------------------------------------------------------------
// A truth load is written as it leaves the queue; a track scans each loaded truth
// entry (read, square, sum, one 22-step square root, compare), gates the nearest
// and, on a match with an id below HISTORY_DEPTH, updates the history. End of frame:
// the 38-step divide, then the result is registered. One transaction is in the back
// end at a time, two more held in the queue. Reset: async active low; the history
// memory is swept clear after reset; no transaction leaves the queue until it ends.
module gated_nearest_track_association_unit #(
    parameter int TRUTH_DEPTH   = gnta_pkg::TRUTH_DEPTH_DEF,
    parameter int HISTORY_DEPTH = gnta_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  gnta_pkg::gnta_in_t              in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output gnta_pkg::gnta_out_t             out_data,
    input  logic                            cfg_we,
    input  logic [gnta_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  logic [gnta_pkg::CFG_DATA_W-1:0] cfg_data
);
    logic               q_valid, q_pop;
    gnta_pkg::gnta_in_t q_data;

    // front end: accept, drop ignored transactions, queue
    gnta_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .in_data(in_data), .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data)
    );

    // back end: scan, root, gate, history, divide
    gnta_back #(.TRUTH_DEPTH(TRUTH_DEPTH), .HISTORY_DEPTH(HISTORY_DEPTH)) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data),
        .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );
endmodule

>>> sv/gnta_ram.sv
// ----------------------------------------------------------------------------
// gnta_ram: generic single-port-write, single-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module gnta_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> sv/gnta_front.sv
// ----------------------------------------------------------------------------
// gnta_front: input stage and queue
// Accept transactions, drop ignored ones, hold a short queue for the back end.
// ----------------------------------------------------------------------------
module gnta_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  gnta_pkg::gnta_in_t in_data,
    output logic               q_valid,
    input  logic               q_pop,
    output gnta_pkg::gnta_in_t q_data
);
    localparam int QD = 2;
    gnta_pkg::gnta_in_t q_reg [QD];
    logic [1:0] cnt_reg;
    logic       rd_reg, wr_reg;
    logic       push, keep;

    assign in_stall = (cnt_reg == 2'd2);
    // drop unused codes and inactive tracks at the door
    assign keep = (in_data.req_type == gnta_pkg::REQ_LOAD) ||
                  (in_data.req_type == gnta_pkg::REQ_EOF) ||
                  (in_data.req_type == gnta_pkg::REQ_TRACK && in_data.track_active);
    assign push    = in_valid && !in_stall && keep;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_data  = q_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= ~wr_reg;
            end
            if (q_pop)
            begin
                rd_reg <= ~rd_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_reg] <= in_data;
        end
    end
endmodule

>>> sv/gnta_back.sv
// ----------------------------------------------------------------------------
// gnta_back: association engine
// Scan truth table, iterative square root, gating, history, frame divide.
// ----------------------------------------------------------------------------
module gnta_back #(
    parameter int TRUTH_DEPTH   = gnta_pkg::TRUTH_DEPTH_DEF,
    parameter int HISTORY_DEPTH = gnta_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              q_valid,
    output logic                              q_pop,
    input  gnta_pkg::gnta_in_t                q_data,
    input  logic                              cfg_we,
    input  logic [gnta_pkg::CFG_IDX_W-1:0]    cfg_idx,
    input  logic [gnta_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output gnta_pkg::gnta_out_t               out_data
);
    localparam int TA_W = (TRUTH_DEPTH > 1) ? $clog2(TRUTH_DEPTH) : 1;
    localparam int TC_W = $clog2(TRUTH_DEPTH + 1);
    localparam int HA_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int HC_W = $clog2(HISTORY_DEPTH + 1);
    localparam int PW   = 3 * gnta_pkg::COORD_W;
    localparam int SQ_W = gnta_pkg::SQ_W;
    localparam int DW   = gnta_pkg::DIST_W;
    localparam int SW   = gnta_pkg::SUM_W;

    logic [15:0] gate_base_reg, gate_slope_reg, min_depth_reg, def_depth_reg;

    gnta_pkg::gnta_state_t state_reg, state_next;
    gnta_pkg::gnta_in_t    item_reg;
    logic [TC_W-1:0] entries_reg;
    logic            overflow_reg;
    logic [15:0]     act_reg, sw_reg, frag_reg, match_reg;
    logic [SW-1:0]   sum_reg;
    logic [TC_W-1:0] scan_reg;
    logic            found_reg;
    logic [DW-1:0]   near_reg;
    logic [TA_W-1:0] near_idx_reg;
    logic [TA_W-1:0] cur_idx_reg;
    logic [41:0]     sqx_reg, sqy_reg, sqz_reg;
    logic [SQ_W-1:0] rem_reg;
    logic [SQ_W-1:0] root_reg;
    logic [4:0]      step_reg;
    logic [HC_W-1:0] clr_reg;
    logic [SW-1:0]   div_rem_reg;
    logic [5:0]      div_cnt_reg;
    logic [SW-1:0]   quo_reg;
    gnta_pkg::gnta_out_t out_reg;
    logic            out_valid_reg;

    // truth RAM
    logic            t_we;
    logic [PW+15:0]  t_rdata;
    logic [TA_W-1:0] t_raddr;
    gnta_ram #(.WIDTH(PW + 16), .DEPTH(TRUTH_DEPTH)) u_truth (
        .clk(clk), .we(t_we), .waddr(entries_reg[TA_W-1:0]),
        .wdata({q_data.pos_x, q_data.pos_y, q_data.pos_z, q_data.object_id}),
        .raddr(t_raddr), .rdata(t_rdata)
    );

    // history RAM: valid + id, cleared by a sweep after reset
    logic            h_we;
    logic [HA_W-1:0] h_waddr;
    logic [16:0]     h_wdata, h_rdata;
    gnta_ram #(.WIDTH(17), .DEPTH(HISTORY_DEPTH)) u_hist (
        .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
        .raddr(item_reg.object_id[HA_W-1:0]), .rdata(h_rdata)
    );

    logic clearing;
    assign clearing = (clr_reg != HC_W'(HISTORY_DEPTH));

    // differences
    logic signed [20:0] dx, dy, dz;
    assign dx = 21'(item_reg.pos_x) - 21'($signed(t_rdata[PW+15 -: 20]));
    assign dy = 21'(item_reg.pos_y) - 21'($signed(t_rdata[PW-5 -: 20]));
    assign dz = 21'(item_reg.pos_z) - 21'($signed(t_rdata[PW-25 -: 20]));

    // square root: one result bit per cycle
    logic [SQ_W-1:0] trial;
    logic [SQ_W-1:0] bitv;
    logic [DW-1:0]   root_dist;
    assign bitv      = SQ_W'(1) << {step_reg, 1'b0};
    assign trial     = root_reg + bitv;
    assign root_dist = root_reg[DW-1:0];

    // gate
    logic [20:0] gate;
    logic        in_hist;
    logic [35:0] prod_full;
    assign prod_full = (($signed(item_reg.pos_z) < $signed({4'b0, min_depth_reg}))
                        ? {20'b0, def_depth_reg} : {16'b0, item_reg.pos_z}) * gate_slope_reg;
    logic [20:0] gate_w;
    assign gate_w = 21'(gate_base_reg) + 21'(prod_full[35:16]);
    assign gate = gate_w;
    assign in_hist = 32'(item_reg.object_id) < 32'(HISTORY_DEPTH);

    logic [SW-1:0] sum_add;
    logic [SW:0]   sum_w;
    assign sum_w   = {1'b0, sum_reg} + (SW+1)'(near_reg);
    assign sum_add = sum_w[SW] ? {SW{1'b1}} : sum_w[SW-1:0];

    // divider trial
    logic [SW:0] drem_sh;
    assign drem_sh = {div_rem_reg, quo_reg[SW-1]};

    // read back the matched truth identity for the history update
    assign t_raddr = (state_reg == gnta_pkg::ST_HRD || state_reg == gnta_pkg::ST_HWAIT)
                     ? near_idx_reg : scan_reg[TA_W-1:0];
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gate_base_reg  <= 16'd300;
            gate_slope_reg <= 16'd3277;
            min_depth_reg  <= 16'd100;
            def_depth_reg  <= 16'd1000;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                gnta_pkg::CFG_GATE_BASE:  gate_base_reg  <= cfg_data;
                gnta_pkg::CFG_GATE_SLOPE: gate_slope_reg <= cfg_data;
                gnta_pkg::CFG_MIN_DEPTH:  min_depth_reg  <= cfg_data;
                gnta_pkg::CFG_DEF_DEPTH:  def_depth_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        q_pop = 1'b0;
        t_we  = 1'b0;
        h_we  = clearing;
        h_waddr = clr_reg[HA_W-1:0];
        h_wdata = '0;
        unique case (state_reg)
            gnta_pkg::ST_IDLE:
            begin
                if (q_valid && !clearing)
                begin
                    q_pop = 1'b1;
                    if (q_data.req_type == gnta_pkg::REQ_LOAD)
                    begin
                        t_we = (entries_reg != TC_W'(TRUTH_DEPTH));
                    end
                    else if (q_data.req_type == gnta_pkg::REQ_TRACK)
                    begin
                        state_next = gnta_pkg::ST_RD;
                    end
                    else
                    begin
                        state_next = gnta_pkg::ST_DIV;
                    end
                end
            end
            gnta_pkg::ST_RD:
                state_next = (scan_reg == entries_reg) ? gnta_pkg::ST_GATE : gnta_pkg::ST_SQ;
            gnta_pkg::ST_SQ:   state_next = gnta_pkg::ST_SUM;
            gnta_pkg::ST_SUM:  state_next = gnta_pkg::ST_ROOT;
            gnta_pkg::ST_ROOT:
                if (step_reg == 5'd0) state_next = gnta_pkg::ST_NEXT;
            gnta_pkg::ST_NEXT: state_next = gnta_pkg::ST_RD;
            gnta_pkg::ST_GATE:
                state_next = (found_reg && near_reg < DW'(gate) && in_hist)
                             ? gnta_pkg::ST_HRD : gnta_pkg::ST_IDLE;
            gnta_pkg::ST_HRD:   state_next = gnta_pkg::ST_HWAIT;
            gnta_pkg::ST_HWAIT: state_next = gnta_pkg::ST_HUPD;
            gnta_pkg::ST_HUPD:
            begin
                h_we = 1'b1;
                h_waddr = item_reg.object_id[HA_W-1:0];
                h_wdata = {1'b1, t_rdata[15:0]};
                state_next = gnta_pkg::ST_IDLE;
            end
            gnta_pkg::ST_DIV:
                if (div_cnt_reg == 6'd0) state_next = gnta_pkg::ST_OUT;
            gnta_pkg::ST_OUT:
                if (!out_valid_reg || !out_stall) state_next = gnta_pkg::ST_IDLE;
            default: state_next = gnta_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gnta_pkg::ST_IDLE;
            entries_reg   <= '0;
            overflow_reg  <= 1'b0;
            act_reg       <= '0;
            sw_reg        <= '0;
            frag_reg      <= '0;
            match_reg     <= '0;
            sum_reg       <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            scan_reg      <= '0;
            found_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (clearing)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (out_valid_reg && !out_stall && state_reg != gnta_pkg::ST_OUT)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                gnta_pkg::ST_IDLE:
                begin
                    if (q_pop && q_data.req_type == gnta_pkg::REQ_LOAD)
                    begin
                        if (t_we) entries_reg <= entries_reg + 1'b1;
                        else overflow_reg <= 1'b1;
                    end
                    if (q_pop && q_data.req_type == gnta_pkg::REQ_TRACK)
                    begin
                        act_reg   <= gnta_pkg::sat_inc(act_reg);
                        scan_reg  <= '0;
                        found_reg <= 1'b0;
                    end
                end
                gnta_pkg::ST_NEXT:
                begin
                    if (!found_reg || root_dist < near_reg)
                    begin
                        found_reg <= 1'b1;
                    end
                    scan_reg <= scan_reg + 1'b1;
                end
                gnta_pkg::ST_GATE:
                begin
                    if (found_reg && near_reg < DW'(gate))
                    begin
                        match_reg <= gnta_pkg::sat_inc(match_reg);
                        sum_reg   <= sum_add;
                    end
                    else
                    begin
                        frag_reg <= gnta_pkg::sat_inc(frag_reg);
                    end
                end
                gnta_pkg::ST_HUPD:
                begin
                    if (h_rdata[16] && h_rdata[15:0] != t_rdata[15:0])
                    begin
                        sw_reg <= gnta_pkg::sat_inc(sw_reg);
                    end
                end
                gnta_pkg::ST_OUT:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        entries_reg  <= '0;
                        overflow_reg <= 1'b0;
                        act_reg <= '0;
                        sw_reg <= '0;
                        frag_reg <= '0;
                        match_reg <= '0;
                        sum_reg <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            gnta_pkg::ST_IDLE:
            begin
                if (q_pop)
                begin
                    item_reg    <= q_data;
                    div_rem_reg <= '0;
                    quo_reg     <= '0;
                    div_cnt_reg <= 6'(SW + 1);
                end
            end
            gnta_pkg::ST_RD:
                cur_idx_reg <= scan_reg[TA_W-1:0];
            gnta_pkg::ST_SQ:
            begin
                sqx_reg <= 42'(dx * dx);
                sqy_reg <= 42'(dy * dy);
                sqz_reg <= 42'(dz * dz);
            end
            gnta_pkg::ST_SUM:
            begin
                rem_reg  <= SQ_W'(sqx_reg) + SQ_W'(sqy_reg) + SQ_W'(sqz_reg);
                root_reg <= '0;
                step_reg <= 5'd21;
            end
            gnta_pkg::ST_ROOT:
            begin
                // one bit of the root per cycle; root_reg holds root scaled as in
                // the classic digit-by-digit loop
                if (rem_reg >= trial)
                begin
                    rem_reg  <= rem_reg - trial;
                    root_reg <= (root_reg >> 1) + bitv;
                end
                else
                begin
                    root_reg <= root_reg >> 1;
                end
                step_reg <= step_reg - 1'b1;
            end
            gnta_pkg::ST_NEXT:
            begin
                if (!found_reg || root_dist < near_reg)
                begin
                    near_reg     <= root_dist;
                    near_idx_reg <= cur_idx_reg;
                end
            end
            gnta_pkg::ST_GATE:
                ;
            gnta_pkg::ST_HRD:
                ;
            gnta_pkg::ST_HWAIT:
                ;
            gnta_pkg::ST_DIV:
            begin
                // restoring divide, one quotient bit per cycle
                if (div_cnt_reg == 6'(SW + 1))
                begin
                    quo_reg <= sum_reg;
                    div_cnt_reg <= div_cnt_reg - 1'b1;
                end
                else if (div_cnt_reg != 6'd0)
                begin
                    if (match_reg != 16'd0 && drem_sh >= (SW+1)'(match_reg))
                    begin
                        div_rem_reg <= SW'(drem_sh - (SW+1)'(match_reg));
                        quo_reg     <= {quo_reg[SW-2:0], 1'b1};
                    end
                    else
                    begin
                        div_rem_reg <= drem_sh[SW-1:0];
                        quo_reg     <= {quo_reg[SW-2:0], 1'b0};
                    end
                    div_cnt_reg <= div_cnt_reg - 1'b1;
                end
            end
            gnta_pkg::ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_reg.active_tracks  <= act_reg;
                    out_reg.ident_changes  <= sw_reg;
                    out_reg.fragmentations <= frag_reg;
                    out_reg.matched_pairs  <= match_reg;
                    out_reg.avg_error_mm   <= (match_reg == 16'd0) ? '0 :
                        ((|quo_reg[SW-1:22]) ? {22{1'b1}} : quo_reg[21:0]);
                    out_reg.truth_dropped  <= overflow_reg;
                end
            end
            default: ;
        endcase
    end
endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top: gated nearest track association unit testbench
// Drives frames of truth loads, tracks and end-of-frame requests, predicts the
// per-frame figures in a local model and compares every result transaction.
// ============================================================================
module tb_top;

    localparam int  TRUTH_SLOTS   = gnta_pkg::TRUTH_DEPTH_DEF;
    localparam int  HISTORY_SLOTS = gnta_pkg::HISTORY_DEPTH_DEF;
    localparam longint CYCLE_LIMIT = 10000000;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    logic                            clk;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_stall;
    gnta_pkg::gnta_in_t              in_data;
    logic                            out_valid;
    logic                            out_stall;
    gnta_pkg::gnta_out_t             out_data;
    logic                            cfg_we;
    logic [gnta_pkg::CFG_IDX_W-1:0]  cfg_idx;
    logic [gnta_pkg::CFG_DATA_W-1:0] cfg_data;

    gated_nearest_track_association_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_data  (cfg_data)
    );

    // Mirror of the configuration registers
    logic [15:0] gate_base;
    logic [15:0] gate_slope;
    logic [15:0] min_depth;
    logic [15:0] default_depth;

    // Mirror of the frame state: truth table, identity history, tallies
    int          truth_x [TRUTH_SLOTS];
    int          truth_y [TRUTH_SLOTS];
    int          truth_z [TRUTH_SLOTS];
    logic [15:0] truth_id [TRUTH_SLOTS];
    int          truth_count;
    bit          truth_full;
    bit          hist_valid [HISTORY_SLOTS];
    logic [15:0] hist_truth [HISTORY_SLOTS];
    int          n_active, n_switch, n_frag, n_match;
    longint unsigned err_sum;

    gnta_pkg::gnta_out_t frame_reports [$];

    int     mismatches;
    int     frames_checked;
    int     tracks_sent;
    longint cycles;
    bit     in_gaps_on;
    bit     out_stalls_on;
    int     holdoff_left;
    int     out_burst_left;

    // ------------------------------------------------------------------------
    // Clock, cycle limit
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Local model
    // ------------------------------------------------------------------------
    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= root + bitv)
            begin
                n    = n - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic logic [15:0] tally_up(input int v);
        return (v >= 65535) ? 16'hFFFF : 16'(v + 1);
    endfunction

    function automatic void clear_frame();
        truth_count = 0;
        truth_full  = 1'b0;
        n_active    = 0;
        n_switch    = 0;
        n_frag      = 0;
        n_match     = 0;
        err_sum     = 0;
    endfunction

    function automatic void associate_track(input gnta_pkg::gnta_in_t t);
        bit              found;
        longint unsigned nearest;
        int              nearest_idx;
        longint          dx, dy, dz, depth;
        longint unsigned span, gate;
        logic [15:0]     tid;
        found       = 1'b0;
        nearest     = 0;
        nearest_idx = 0;
        n_active    = tally_up(n_active);
        for (int j = 0; j < truth_count; j++)
        begin
            dx   = longint'(t.pos_x) - truth_x[j];
            dy   = longint'(t.pos_y) - truth_y[j];
            dz   = longint'(t.pos_z) - truth_z[j];
            span = int_sqrt(dx * dx + dy * dy + dz * dz);
            // strict compare: the lowest index keeps a tie
            if (!found || span < nearest)
            begin
                found       = 1'b1;
                nearest     = span;
                nearest_idx = j;
            end
        end
        depth = longint'(t.pos_z);
        if (depth < longint'(min_depth))
            depth = longint'(default_depth);
        gate = longint'(gate_base) + ((depth * longint'(gate_slope)) >>> 16);
        if (found && nearest < gate)
        begin
            tid     = truth_id[nearest_idx];
            err_sum = err_sum + nearest;
            if (err_sum > ((64'd1 << 38) - 1))
                err_sum = (64'd1 << 38) - 1;
            n_match = tally_up(n_match);
            if (t.object_id < HISTORY_SLOTS)
            begin
                if (hist_valid[t.object_id] && hist_truth[t.object_id] != tid)
                    n_switch = tally_up(n_switch);
                hist_valid[t.object_id] = 1'b1;
                hist_truth[t.object_id] = tid;
            end
        end
        else
            n_frag = tally_up(n_frag);
    endfunction

    function automatic void predict_request(input gnta_pkg::gnta_in_t t);
        gnta_pkg::gnta_out_t r;
        longint unsigned     avg;
        case (t.req_type)
            gnta_pkg::REQ_LOAD:
            begin
                if (truth_count < TRUTH_SLOTS)
                begin
                    truth_x[truth_count]  = int'(t.pos_x);
                    truth_y[truth_count]  = int'(t.pos_y);
                    truth_z[truth_count]  = int'(t.pos_z);
                    truth_id[truth_count] = t.object_id;
                    truth_count++;
                end
                else
                    truth_full = 1'b1;
            end
            gnta_pkg::REQ_TRACK:
            begin
                if (t.track_active)
                    associate_track(t);
            end
            gnta_pkg::REQ_EOF:
            begin
                avg = (n_match > 0) ? err_sum / longint'(n_match) : 0;
                if (avg > 4194303)
                    avg = 4194303;
                r.active_tracks  = 16'(n_active);
                r.ident_changes  = 16'(n_switch);
                r.fragmentations = 16'(n_frag);
                r.matched_pairs  = 16'(n_match);
                r.avg_error_mm   = 22'(avg);
                r.truth_dropped  = truth_full;
                frame_reports.push_back(r);
                clear_frame();
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------
    task automatic report(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0d, expected %0d (frame %0d)",
                 what, got, want, frames_checked);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        gnta_pkg::gnta_out_t w;
        if (rst_n && out_valid && !out_stall)
        begin
            if (frame_reports.size() == 0)
                report("unexpected result", 1, 0);
            else
            begin
                w = frame_reports.pop_front();
                if (out_data.active_tracks != w.active_tracks)
                    report("active_tracks", out_data.active_tracks, w.active_tracks);
                if (out_data.ident_changes != w.ident_changes)
                    report("ident_changes", out_data.ident_changes, w.ident_changes);
                if (out_data.fragmentations != w.fragmentations)
                    report("fragmentations", out_data.fragmentations, w.fragmentations);
                if (out_data.matched_pairs != w.matched_pairs)
                    report("matched_pairs", out_data.matched_pairs, w.matched_pairs);
                if (out_data.avg_error_mm != w.avg_error_mm)
                    report("avg_error_mm", out_data.avg_error_mm, w.avg_error_mm);
                if (out_data.truth_dropped != w.truth_dropped)
                    report("truth_dropped", out_data.truth_dropped, w.truth_dropped);
            end
            frames_checked++;
        end
    end

    // Receiver stall: long hold-off first, then random bursts when enabled
    always @(posedge clk)
    begin
        if (holdoff_left > 0)
        begin
            out_stall <= 1'b1;
            holdoff_left <= holdoff_left - 1;
        end
        else if (out_burst_left > 0)
        begin
            out_stall <= 1'b1;
            out_burst_left <= out_burst_left - 1;
        end
        else if (out_stalls_on && $urandom_range(0, 9) == 0)
        begin
            out_stall <= 1'b1;
            out_burst_left <= $urandom_range(0, 15);
        end
        else
            out_stall <= 1'b0;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic gnta_pkg::gnta_in_t make_req(input logic [1:0] req, input int x,
                                                    input int y, input int z, input int id,
                                                    input bit act);
        gnta_pkg::gnta_in_t t;
        t.req_type     = req;
        t.pos_x        = 20'(x);
        t.pos_y        = 20'(y);
        t.pos_z        = 20'(z);
        t.object_id    = 16'(id);
        t.track_active = act;
        return t;
    endfunction

    // Offer one transaction; hold it until the block takes it
    task automatic send_req(input gnta_pkg::gnta_in_t t);
        if (in_gaps_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= t;
        do
            @(posedge clk);
        while (in_stall);
        predict_request(t);
        if (t.req_type == gnta_pkg::REQ_TRACK)
            tracks_sent++;
    endtask

    // Drop valid and wait until every frame report has arrived
    task automatic drain();
        in_valid <= 1'b0;
        while (frame_reports.size() != 0)
            @(posedge clk);
        repeat (64) @(posedge clk);
    endtask

    task automatic write_reg(input logic [gnta_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            gnta_pkg::CFG_GATE_BASE:  gate_base     = val;
            gnta_pkg::CFG_GATE_SLOPE: gate_slope    = val;
            gnta_pkg::CFG_MIN_DEPTH:  min_depth     = val;
            gnta_pkg::CFG_DEF_DEPTH:  default_depth = val;
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [15:0] base, input logic [15:0] slope,
                              input logic [15:0] mind, input logic [15:0] defd);
        write_reg(gnta_pkg::CFG_GATE_BASE, base);
        write_reg(gnta_pkg::CFG_GATE_SLOPE, slope);
        write_reg(gnta_pkg::CFG_MIN_DEPTH, mind);
        write_reg(gnta_pkg::CFG_DEF_DEPTH, defd);
    endtask

    function automatic int any_coord();
        return int'($urandom_range(0, 20'hFFFFF)) - 524288;
    endfunction

    // One random frame: mostly small truth sets with tracks placed near them
    task automatic random_frame(inout int budget);
        int n_truth, n_tracks, k, spread;
        int lx [$], ly [$], lz [$];
        gnta_pkg::gnta_in_t t;
        n_truth  = ($urandom_range(0, 24) == 0) ? $urandom_range(62, 68)
                                                : $urandom_range(0, 6);
        n_tracks = (n_truth > 10) ? $urandom_range(1, 2) : $urandom_range(1, 8);
        for (int i = 0; i < n_truth; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                t = make_req(gnta_pkg::REQ_LOAD, any_coord(), any_coord(), any_coord(),
                             $urandom_range(0, 65535), 1'($urandom_range(0, 1)));
            else
                t = make_req(gnta_pkg::REQ_LOAD, $urandom_range(0, 8000) - 4000,
                             $urandom_range(0, 8000) - 4000, $urandom_range(0, 6000),
                             $urandom_range(0, 12), 1'($urandom_range(0, 1)));
            lx.push_back(int'(t.pos_x));
            ly.push_back(int'(t.pos_y));
            lz.push_back(int'(t.pos_z));
            send_req(t);
            budget--;
        end
        for (int i = 0; i < n_tracks; i++)
        begin
            if (lx.size() > 0 && $urandom_range(0, 4) != 0)
            begin
                k      = $urandom_range(0, lx.size() - 1);
                spread = $urandom_range(0, 3) == 0 ? 2000 : 300;
                t = make_req(gnta_pkg::REQ_TRACK,
                             lx[k] + $urandom_range(0, 2 * spread) - spread,
                             ly[k] + $urandom_range(0, 2 * spread) - spread,
                             lz[k] + $urandom_range(0, 2 * spread) - spread,
                             $urandom_range(0, 30), 1'b1);
                if ($urandom_range(0, 15) == 0)
                    t.object_id = 16'($urandom_range(1024, 65535));
            end
            else
                t = make_req(gnta_pkg::REQ_TRACK, any_coord(), any_coord(), any_coord(),
                             $urandom_range(0, 65535), 1'b1);
            if ($urandom_range(0, 9) == 0)
                t.track_active = 1'b0;
            send_req(t);
            budget--;
            // occasional unused request code as noise
            if ($urandom_range(0, 19) == 0)
                send_req(make_req(REQ_UNUSED, any_coord(), any_coord(), any_coord(),
                                  $urandom_range(0, 65535), 1'($urandom_range(0, 1))));
        end
        send_req(make_req(gnta_pkg::REQ_EOF, any_coord(), any_coord(), any_coord(),
                          $urandom_range(0, 65535), 1'($urandom_range(0, 1))));
        budget--;
    endtask

    task automatic random_phase(input int n_items);
        int budget;
        budget = n_items;
        while (budget > 0)
            random_frame(budget);
        drain();
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_directed();
        // field extremes, nearest tie, shallow and negative depth
        send_req(make_req(gnta_pkg::REQ_LOAD, -524288, 524287, 0, 65535, 1'b0));
        send_req(make_req(gnta_pkg::REQ_LOAD, 100, 0, 500, 7, 1'b1));
        send_req(make_req(gnta_pkg::REQ_LOAD, -100, 0, 500, 8, 1'b1));
        send_req(make_req(gnta_pkg::REQ_TRACK, 0, 0, 500, 3, 1'b1));
        send_req(make_req(gnta_pkg::REQ_TRACK, 524287, -524288, -524288, 65535, 1'b1));
        send_req(make_req(gnta_pkg::REQ_TRACK, 100, 0, 50, 4, 1'b1));
        send_req(make_req(gnta_pkg::REQ_TRACK, -100, 0, -40, 1024, 1'b1));
        send_req(make_req(gnta_pkg::REQ_TRACK, 100, 0, 500, 5, 1'b0));
        send_req(make_req(REQ_UNUSED, 524287, 524287, 524287, 65535, 1'b1));
        send_req(make_req(gnta_pkg::REQ_EOF, 0, 0, 0, 0, 1'b0));
        // identity switch: track 3 moves from truth 7 to truth 9
        send_req(make_req(gnta_pkg::REQ_LOAD, 100, 0, 500, 9, 1'b0));
        send_req(make_req(gnta_pkg::REQ_TRACK, 110, 5, 505, 3, 1'b1));
        send_req(make_req(gnta_pkg::REQ_TRACK, 90, 0, 495, 3, 1'b1));
        send_req(make_req(gnta_pkg::REQ_EOF, 0, 0, 0, 0, 1'b1));
        // tracks with no truth loaded
        send_req(make_req(gnta_pkg::REQ_TRACK, 0, 0, 0, 0, 1'b1));
        send_req(make_req(gnta_pkg::REQ_TRACK, 1, 2, 3, 1023, 1'b1));
        send_req(make_req(gnta_pkg::REQ_EOF, 0, 0, 0, 0, 1'b0));
        drain();
    endtask

    task automatic test_truth_overflow();
        for (int i = 0; i < TRUTH_SLOTS + 3; i++)
            send_req(make_req(gnta_pkg::REQ_LOAD, i * 50, -i * 30, 1000 + i, i, 1'b1));
        send_req(make_req(gnta_pkg::REQ_TRACK, 3180, -1910, 1063, 12, 1'b1));
        send_req(make_req(gnta_pkg::REQ_EOF, 0, 0, 0, 0, 1'b0));
        drain();
    endtask

    task automatic test_gate_settings();
        set_config(16'd0, 16'd65535, 16'd0, 16'd0);
        random_phase(120);
        set_config(16'd65535, 16'd0, 16'd65535, 16'd65535);
        random_phase(100);
        set_config(16'd1, 16'd65535, 16'd65535, 16'd65535);
        random_phase(100);
        set_config(16'($urandom_range(0, 1000)), 16'($urandom_range(0, 20000)),
                   16'($urandom_range(0, 3000)), 16'($urandom_range(0, 8000)));
        random_phase(120);
        set_config(16'd300, 16'd3277, 16'd100, 16'd1000);
    endtask

    task automatic test_output_holdoff();
        // receiver holds off while short frames keep coming, so the block backs up
        holdoff_left = 3000;
        for (int i = 0; i < 40; i++)
        begin
            send_req(make_req(gnta_pkg::REQ_LOAD, i, i, 200 + i, i, 1'b1));
            send_req(make_req(gnta_pkg::REQ_TRACK, i + 5, i, 200 + i, i, 1'b1));
            send_req(make_req(gnta_pkg::REQ_EOF, 0, 0, 0, 0, 1'b0));
        end
        drain();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n          <= 1'b0;
        in_valid       <= 1'b0;
        in_data        <= '0;
        out_stall      <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_idx        <= gnta_pkg::CFG_GATE_BASE;
        cfg_data       <= '0;
        cycles          = 0;
        mismatches      = 0;
        frames_checked  = 0;
        tracks_sent     = 0;
        holdoff_left    = 0;
        out_burst_left  = 0;
        in_gaps_on      = 1'b1;
        out_stalls_on   = 1'b1;
        gate_base       = 16'd300;
        gate_slope      = 16'd3277;
        min_depth       = 16'd100;
        default_depth   = 16'd1000;
        for (int i = 0; i < HISTORY_SLOTS; i++)
        begin
            hist_valid[i] = 1'b0;
            hist_truth[i] = '0;
        end
        clear_frame();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_truth_overflow();
        test_gate_settings();
        test_output_holdoff();
        random_phase(100);

        // closing stretch runs with no idling on either side
        in_gaps_on    = 1'b0;
        out_stalls_on = 1'b0;
        random_phase(80);

        $display("covered %0d frames and %0d tracks over %0d cycles,", frames_checked,
                 tracks_sent, cycles);
        $display("across extreme gate settings, a full truth table and receiver hold-off");
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
